// ===== src/ryam_pkg.sv =====
package ryam_pkg;

   // CSR register indexes
   localparam logic [2:0] REG_START_YAW       = 3'd0;
   localparam logic [2:0] REG_PITCH_DIRECT    = 3'd1;
   localparam logic [2:0] REG_ROLL_DIRECT     = 3'd2;
   localparam logic [2:0] REG_HOVER_UPPER     = 3'd3;
   localparam logic [2:0] REG_HOVER_LOWER     = 3'd4;
   localparam logic [2:0] REG_ALTITUDE_OFFSET = 3'd5;
   localparam logic [2:0] REG_HOVER_INITIAL   = 3'd6;

   // serial multiplier
   localparam int          COEF_W     = 21;
   localparam int          MCAND_W    = 17;
   localparam int          PROD_W     = 38;
   localparam logic [20:0] GAIN_COEF  = 21'd39797;    // 1/K in Q16
   localparam logic [20:0] STEP_COEF  = 21'd1073742;  // 0.001 in Q30

   // rotator
   localparam int                 VEC_W       = 36;
   localparam int                 ANG_W       = 30;
   localparam int                 RES_W       = 20;
   localparam logic signed [29:0] PI_Q24      = 30'sd52707179;
   localparam logic signed [29:0] TWO_PI_Q24  = 30'sd105414358;
   localparam logic signed [29:0] HALF_PI_Q24 = 30'sd26353589;

   localparam logic [15:0] HOVER_INIT_RESET = 16'd16384;
   localparam logic [15:0] HOVER_UP_RESET   = 16'd32768;

   // arctan(2^-i) in Q24
   function automatic logic signed [29:0] arc_lookup(input logic [3:0] idx);
      logic signed [29:0] r;
      unique case (idx)
         4'd0:    r = 30'sd13176795;
         4'd1:    r = 30'sd7778716;
         4'd2:    r = 30'sd4110060;
         4'd3:    r = 30'sd2086331;
         4'd4:    r = 30'sd1047214;
         4'd5:    r = 30'sd524117;
         4'd6:    r = 30'sd262124;
         4'd7:    r = 30'sd131070;
         4'd8:    r = 30'sd65536;
         4'd9:    r = 30'sd32768;
         4'd10:   r = 30'sd16384;
         4'd11:   r = 30'sd8192;
         4'd12:   r = 30'sd4096;
         4'd13:   r = 30'sd2048;
         4'd14:   r = 30'sd1024;
         default: r = 30'sd512;
      endcase
      return r;
   endfunction

   // saturate a 21-bit signed value to 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
      logic signed [15:0] r;
      if (v > 21'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -21'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== src/ryam_mul.sv =====
// Shift-add multiplier: one coefficient bit per cycle; the product is valid when done is raised.
module ryam_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [ryam_pkg::MCAND_W-1:0]    mcand,
   input  logic        [ryam_pkg::COEF_W-1:0]     coef,
   output logic signed [ryam_pkg::PROD_W-1:0]     product,
   output logic                                   done
);

   logic signed [ryam_pkg::PROD_W-1:0] mcand_ff, mcand_in;
   logic signed [ryam_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic        [ryam_pkg::COEF_W-1:0] coef_ff, coef_in;
   logic        [4:0]                  count_ff, count_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;

   // next-state: add shifted multiplicand when the low coefficient bit is set
   always_comb begin
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      coef_in  = coef_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         mcand_in = ryam_pkg::PROD_W'(mcand);
         acc_in   = '0;
         coef_in  = coef;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (coef_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         coef_in  = coef_ff >> 1;
         count_in = count_ff + 5'd1;
         if (count_ff == 5'(ryam_pkg::COEF_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      coef_ff  <= coef_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

// ===== src/ryam_cordic.sv =====
// Iterative rotator: angle wrap, quadrant fold, then 16 CORDIC steps, one per cycle.
module ryam_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ryam_pkg::VEC_W-1:0]     vx,
   input  logic signed [ryam_pkg::VEC_W-1:0]     vy,
   input  logic signed [ryam_pkg::ANG_W-1:0]     angle,
   output logic signed [ryam_pkg::RES_W-1:0]     px,
   output logic signed [ryam_pkg::RES_W-1:0]     py,
   output logic                                  done
);

   typedef enum logic [2:0] {C_IDLE, C_WRAP, C_FOLD, C_ROT, C_DONE} cstate_type;

   cstate_type                          state_ff, state_in;
   logic signed [ryam_pkg::VEC_W-1:0]   vx_ff, vx_in, vy_ff, vy_in;
   logic signed [ryam_pkg::ANG_W-1:0]   ang_ff, ang_in;
   logic        [3:0]                   step_ff, step_in;
   logic signed [ryam_pkg::VEC_W-1:0]   sx, sy, rndx, rndy;

   assign sx = vx_ff >>> step_ff;
   assign sy = vy_ff >>> step_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      ang_in   = ang_ff;
      step_in  = step_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               vx_in    = vx;
               vy_in    = vy;
               ang_in   = angle;
               state_in = C_WRAP;
            end
         end
         C_WRAP: begin
            if (ang_ff > ryam_pkg::PI_Q24) begin
               ang_in = ang_ff - ryam_pkg::TWO_PI_Q24;
            end else if (ang_ff < -ryam_pkg::PI_Q24) begin
               ang_in = ang_ff + ryam_pkg::TWO_PI_Q24;
            end else begin
               state_in = C_FOLD;
            end
         end
         C_FOLD: begin
            if (ang_ff > ryam_pkg::HALF_PI_Q24) begin
               ang_in = ang_ff - ryam_pkg::PI_Q24;
               vx_in  = -vx_ff;
               vy_in  = -vy_ff;
            end else if (ang_ff < -ryam_pkg::HALF_PI_Q24) begin
               ang_in = ang_ff + ryam_pkg::PI_Q24;
               vx_in  = -vx_ff;
               vy_in  = -vy_ff;
            end
            step_in  = '0;
            state_in = C_ROT;
         end
         C_ROT: begin
            if (!ang_ff[ryam_pkg::ANG_W-1]) begin
               vx_in  = vx_ff - sy;
               vy_in  = vy_ff + sx;
               ang_in = ang_ff - ryam_pkg::arc_lookup(step_ff);
            end else begin
               vx_in  = vx_ff + sy;
               vy_in  = vy_ff - sx;
               ang_in = ang_ff + ryam_pkg::arc_lookup(step_ff);
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      ang_ff  <= ang_in;
      step_ff <= step_in;
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // round Q28 results to Q12
   assign rndx = vx_ff + 36'sd32768;
   assign rndy = vy_ff + 36'sd32768;
   assign px   = rndx[35:16];
   assign py   = rndy[35:16];
   assign done = (state_ff == C_DONE);

endmodule

// ===== src/yaw_rotated_attitude_command_mixer.sv =====
// Yaw-rotated attitude command mixer. One word in gives one word out. An accepted
// word runs through a shift-add multiply (rotator prescale and hover-average step),
// a handoff to the rotator, the angle wrap, the quadrant fold and the CORDIC
// iteration, then the finish step. req_stall stays high while a word is in work and
// while the finished word waits for the output register. CSR writes are always
// ready; writing hover_initial also presets the hover average.
module yaw_rotated_attitude_command_mixer (
   input  logic               clock,
   input  logic               reset,
   // input words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_x_command,
   input  logic signed [15:0] req_y_command,
   input  logic signed [15:0] req_heading_command,
   input  logic signed [15:0] req_altitude_command,
   input  logic signed [15:0] req_measured_yaw,
   input  logic signed [15:0] req_stick_roll,
   input  logic signed [15:0] req_stick_pitch,
   input  logic signed [15:0] req_stick_yaw,
   input  logic               req_offboard,
   input  logic               req_pilot_accept,
   input  logic               req_pilot_override,
   input  logic               req_pilot_interrupt,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_roll_out,
   output logic signed [15:0] rsp_pitch_out,
   output logic signed [15:0] rsp_yaw_out,
   output logic        [15:0] rsp_throttle_out,
   output logic               rsp_pilot_in_control,
   // CSR writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [15:0] csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ROT, ST_FINISH} state_type;

   state_type          state_ff;
   logic               accept;

   // CSRs
   logic signed [15:0] start_yaw_ff;
   logic               pitch_direct_ff, roll_direct_ff;
   logic        [15:0] hover_upper_ff, hover_lower_ff;
   logic signed [15:0] altitude_offset_ff;
   logic        [31:0] hover_avg_ff, hover_avg_in;

   // latched word
   logic signed [15:0] x_ff, y_ff, head_ff, alt_ff, myaw_ff, sroll_ff, spitch_ff, syaw_ff;
   logic               offb_ff, pilot_ff;

   // output register
   logic               rsp_valid_ff;
   logic signed [15:0] roll_out_ff, pitch_out_ff, yaw_out_ff;
   logic        [15:0] thr_out_ff;
   logic               pilot_out_ff;

   // datapath
   logic signed [ryam_pkg::PROD_W-1:0] prod_x, prod_y, prod_e;
   logic                               done_x, done_y, done_e, mul_done;
   logic signed [16:0]                 err_in;
   logic signed [ryam_pkg::ANG_W-1:0]  rot_angle;
   logic signed [16:0]                 yaw_diff;
   logic signed [ryam_pkg::RES_W-1:0]  rot_x, rot_y;
   logic                               rot_done;
   logic                               out_free;

   logic signed [15:0] roll_sel, pitch_sel, yaw_cmd, yaw_sat;
   logic signed [16:0] yaw_sum;
   logic signed [34:0] thr_sum, thr_clamped, thr_rnd;
   logic        [15:0] thr_val;
   logic signed [ryam_pkg::PROD_W-1:0] step_rnd;
   logic signed [33:0] avg_next, upper_lim, lower_lim;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // input latch
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff      <= req_x_command;
         y_ff      <= req_y_command;
         head_ff   <= req_heading_command;
         alt_ff    <= req_altitude_command;
         myaw_ff   <= req_measured_yaw;
         sroll_ff  <= req_stick_roll;
         spitch_ff <= req_stick_pitch;
         syaw_ff   <= req_stick_yaw;
         offb_ff   <= req_offboard;
         pilot_ff  <= req_pilot_accept && (req_pilot_override || req_pilot_interrupt);
      end
   end

   // serial multiplies start at accept
   assign err_in = 17'(req_altitude_command) - 17'(altitude_offset_ff);

   ryam_mul u_mul_x (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .mcand   (17'(req_x_command)),
      .coef    (ryam_pkg::GAIN_COEF),
      .product (prod_x),
      .done    (done_x)
   );

   ryam_mul u_mul_y (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .mcand   (17'(req_y_command)),
      .coef    (ryam_pkg::GAIN_COEF),
      .product (prod_y),
      .done    (done_y)
   );

   ryam_mul u_mul_e (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .mcand   (err_in),
      .coef    (ryam_pkg::STEP_COEF),
      .product (prod_e),
      .done    (done_e)
   );

   assign mul_done = done_x && done_y && done_e;

   // angle relative to start yaw, Q24
   assign yaw_diff  = 17'(myaw_ff) - 17'(start_yaw_ff);
   assign rot_angle = ryam_pkg::ANG_W'(yaw_diff) <<< 12;

   ryam_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_MUL && mul_done),
      .vx    (prod_x[ryam_pkg::VEC_W-1:0]),
      .vy    (prod_y[ryam_pkg::VEC_W-1:0]),
      .angle (rot_angle),
      .px    (rot_x),
      .py    (rot_y),
      .done  (rot_done)
   );

   // attitude selection
   always_comb begin
      pitch_sel = pitch_direct_ff ? spitch_ff : ryam_pkg::sat16(21'(rot_x));
      roll_sel  = roll_direct_ff ? sroll_ff : ryam_pkg::sat16(-21'(rot_y));
      yaw_cmd   = head_ff;
      if (pilot_ff) begin
         pitch_sel = spitch_ff;
         roll_sel  = sroll_ff;
         yaw_cmd   = syaw_ff;
      end
      yaw_sum = 17'(myaw_ff) + 17'(yaw_cmd);
      yaw_sat = ryam_pkg::sat16(21'(yaw_sum));
   end

   // throttle from the average before this word's update
   always_comb begin
      thr_sum = (35'(alt_ff) <<< 16) + $signed({3'b000, hover_avg_ff});
      if (thr_sum > 35'sh080000000) begin
         thr_clamped = 35'sh080000000;
      end else if (thr_sum < 35'sd0) begin
         thr_clamped = '0;
      end else begin
         thr_clamped = thr_sum;
      end
      thr_rnd = thr_clamped + 35'sd32768;
      thr_val = thr_rnd[31:16];
   end

   // hover average step and clamp
   always_comb begin
      step_rnd  = (prod_e + 38'sd8192) >>> 14;
      avg_next  = $signed({2'b00, hover_avg_ff}) + 34'(step_rnd);
      upper_lim = $signed({2'b00, hover_upper_ff, 16'h0000});
      lower_lim = $signed({2'b00, hover_lower_ff, 16'h0000});
      hover_avg_in = hover_avg_ff;
      if (state_ff == ST_FINISH && out_free && offb_ff) begin
         if (avg_next > upper_lim) begin
            hover_avg_in = upper_lim[31:0];
         end else if (avg_next < lower_lim) begin
            hover_avg_in = lower_lim[31:0];
         end else begin
            hover_avg_in = avg_next[31:0];
         end
      end
      if (csr_valid && csr_ready && csr_index == ryam_pkg::REG_HOVER_INITIAL) begin
         hover_avg_in = {csr_data, 16'h0000};
      end
   end

   // CSR bank
   always_ff @(posedge clock) begin
      if (reset) begin
         start_yaw_ff       <= '0;
         pitch_direct_ff    <= 1'b0;
         roll_direct_ff     <= 1'b0;
         hover_upper_ff     <= ryam_pkg::HOVER_UP_RESET;
         hover_lower_ff     <= '0;
         altitude_offset_ff <= '0;
         hover_avg_ff       <= {ryam_pkg::HOVER_INIT_RESET, 16'h0000};
      end else begin
         hover_avg_ff <= hover_avg_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ryam_pkg::REG_START_YAW:       start_yaw_ff       <= csr_data;
               ryam_pkg::REG_PITCH_DIRECT:    pitch_direct_ff    <= csr_data[0];
               ryam_pkg::REG_ROLL_DIRECT:     roll_direct_ff     <= csr_data[0];
               ryam_pkg::REG_HOVER_UPPER:     hover_upper_ff     <= csr_data;
               ryam_pkg::REG_HOVER_LOWER:     hover_lower_ff     <= csr_data;
               ryam_pkg::REG_ALTITUDE_OFFSET: altitude_offset_ff <= csr_data;
               // only presets the average, done above
               ryam_pkg::REG_HOVER_INITIAL:   ;
               default: ;
            endcase
         end
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mul_done) begin
                  state_ff <= ST_ROT;
               end
            end
            ST_ROT: begin
               if (rot_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (state_ff == ST_FINISH && out_free) begin
         roll_out_ff  <= roll_sel;
         pitch_out_ff <= pitch_sel;
         yaw_out_ff   <= yaw_sat;
         thr_out_ff   <= thr_val;
         pilot_out_ff <= pilot_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_roll_out         = roll_out_ff;
   assign rsp_pitch_out        = pitch_out_ff;
   assign rsp_yaw_out          = yaw_out_ff;
   assign rsp_throttle_out     = thr_out_ff;
   assign rsp_pilot_in_control = pilot_out_ff;

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL)
      else $error("accepted word did not start the multiplier");

   a_mul_in_phase: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL)
      else $error("multiplier finished outside the multiply phase");

   a_rot_in_phase: assert property (@(posedge clock) disable iff (reset)
      rot_done |-> state_ff == ST_ROT)
      else $error("rotator finished outside the rotate phase");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result word appeared without a finish cycle");

   a_thr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> thr_out_ff <= 16'd32768)
      else $error("throttle above 1.0");

endmodule

// ===== dv/tb_yaw_rotated_attitude_command_mixer.sv =====
module tb_yaw_rotated_attitude_command_mixer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint PI_ANGLE   = 64'sd52707179;
   localparam longint HALF_ANGLE = 64'sd26353589;
   localparam longint INV_GAIN   = 64'sd39797;
   localparam longint AVG_STEP   = 64'sd1073742;
   localparam int     DRAIN_WAIT = 80;
   localparam longint CYCLE_LIMIT = 64'd900000;

   typedef struct packed {
      logic signed [15:0] x_cmd;
      logic signed [15:0] y_cmd;
      logic signed [15:0] heading;
      logic signed [15:0] altitude;
      logic signed [15:0] yaw_meas;
      logic signed [15:0] st_roll;
      logic signed [15:0] st_pitch;
      logic signed [15:0] st_yaw;
      logic               offboard;
      logic               accept;
      logic               override_sw;
      logic               interrupt_sw;
   } tick_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic        [15:0] throttle;
      logic               pilot;
   } attitude_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tick_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_out, rsp_pitch_out, rsp_yaw_out;
   logic [15:0] rsp_throttle_out;
   logic rsp_pilot_in_control;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   // predictor state
   longint sh_start_yaw, sh_upper, sh_lower, sh_offset;
   bit     sh_pitch_direct, sh_roll_direct;
   logic [31:0] hover_avg;

   attitude_type expected_attitudes[$];
   int  error_count = 0;
   longint cycle_count = 0;
   int  stall_mode = 0;

   yaw_rotated_attitude_command_mixer i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_command(req_word.x_cmd), .req_y_command(req_word.y_cmd),
      .req_heading_command(req_word.heading),
      .req_altitude_command(req_word.altitude),
      .req_measured_yaw(req_word.yaw_meas),
      .req_stick_roll(req_word.st_roll), .req_stick_pitch(req_word.st_pitch),
      .req_stick_yaw(req_word.st_yaw), .req_offboard(req_word.offboard),
      .req_pilot_accept(req_word.accept),
      .req_pilot_override(req_word.override_sw),
      .req_pilot_interrupt(req_word.interrupt_sw),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_roll_out(rsp_roll_out), .rsp_pitch_out(rsp_pitch_out),
      .rsp_yaw_out(rsp_yaw_out), .rsp_throttle_out(rsp_throttle_out),
      .rsp_pilot_in_control(rsp_pilot_in_control),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("yaw_rotated_attitude_command_mixer: mismatch");
         $finish;
      end
   end

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint arctan_q24(int i);
      longint angles[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                             262124, 131070, 65536, 32768, 16384, 8192, 4096,
                             2048, 1024, 512};
      return angles[i];
   endfunction

   // CORDIC rotation of (x, y) by angle d (Q12); returns rotated pair in Q12
   task automatic rotate_vector(input longint x, input longint y, input longint d,
                                output longint px, output longint py);
      longint a, vx, vy, sx, sy;
      a  = d * 4096;
      vx = x * INV_GAIN;
      vy = y * INV_GAIN;
      while (a > PI_ANGLE) a -= 2 * PI_ANGLE;
      while (a < -PI_ANGLE) a += 2 * PI_ANGLE;
      if (a > HALF_ANGLE) begin
         a -= PI_ANGLE; vx = -vx; vy = -vy;
      end else if (a < -HALF_ANGLE) begin
         a += PI_ANGLE; vx = -vx; vy = -vy;
      end
      for (int i = 0; i < 16; i++) begin
         sx = floor_shr(vx, i);
         sy = floor_shr(vy, i);
         if (a >= 0) begin
            vx -= sy; vy += sx; a -= arctan_q24(i);
         end else begin
            vx += sy; vy -= sx; a += arctan_q24(i);
         end
      end
      px = floor_shr(vx + 32768, 16);
      py = floor_shr(vy + 32768, 16);
   endtask

   // expected attitude word for one tick; advances the hover average on offboard ticks
   task automatic mix_attitude(input tick_type t, output attitude_type r);
      longint rx, ry, pitch, roll, yawc, thr, na, e;
      bit pilot;
      rotate_vector(longint'(t.x_cmd), longint'(t.y_cmd),
                    longint'(t.yaw_meas) - sh_start_yaw, rx, ry);
      pitch = sh_pitch_direct ? longint'(t.st_pitch) : clip16(rx);
      roll  = sh_roll_direct ? longint'(t.st_roll) : clip16(-ry);
      yawc  = longint'(t.heading);
      thr   = longint'(t.altitude) * 65536 + longint'(hover_avg);
      if (t.offboard) begin
         e  = longint'(t.altitude) - sh_offset;
         na = longint'(hover_avg) + floor_shr(e * AVG_STEP + 8192, 14);
         if (na > (sh_upper << 16)) na = sh_upper << 16;
         else if (na < (sh_lower << 16)) na = sh_lower << 16;
         hover_avg = na[31:0];
      end
      pilot = t.accept && (t.override_sw || t.interrupt_sw);
      if (pilot) begin
         roll  = longint'(t.st_roll);
         pitch = longint'(t.st_pitch);
         yawc  = longint'(t.st_yaw);
      end
      if (thr > (64'sd1 << 31)) thr = 64'sd1 << 31;
      if (thr < 0) thr = 0;
      thr = (thr + 32768) >>> 16;
      r.roll     = roll[15:0];
      r.pitch    = pitch[15:0];
      r.yaw      = 16'(clip16(longint'(t.yaw_meas) + yawc));
      r.throttle = thr[15:0];
      r.pilot    = pilot;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint exp);
      $display("ERROR %s: got %0d expected %0d", what, got, exp);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      attitude_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_attitudes.size() == 0) begin
            report_mismatch("unexpected result word", 0, 0);
         end else begin
            e = expected_attitudes.pop_front();
            if (rsp_roll_out !== e.roll) report_mismatch("roll", rsp_roll_out, e.roll);
            if (rsp_pitch_out !== e.pitch) report_mismatch("pitch", rsp_pitch_out, e.pitch);
            if (rsp_yaw_out !== e.yaw) report_mismatch("yaw", rsp_yaw_out, e.yaw);
            if (rsp_throttle_out !== e.throttle)
               report_mismatch("throttle", rsp_throttle_out, e.throttle);
            if (rsp_pilot_in_control !== e.pilot)
               report_mismatch("pilot", rsp_pilot_in_control, e.pilot);
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
   end

   // one word; valid is dropped after the word is taken, before the next word
   task automatic send_tick(input tick_type t);
      attitude_type r;
      req_word  <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      mix_attitude(t, r);
      expected_attitudes.push_back(r);
      @(negedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ryam_pkg::REG_START_YAW:       sh_start_yaw = longint'($signed(val));
         ryam_pkg::REG_PITCH_DIRECT:    sh_pitch_direct = val[0];
         ryam_pkg::REG_ROLL_DIRECT:     sh_roll_direct = val[0];
         ryam_pkg::REG_HOVER_UPPER:     sh_upper = longint'(val);
         ryam_pkg::REG_HOVER_LOWER:     sh_lower = longint'(val);
         ryam_pkg::REG_ALTITUDE_OFFSET: sh_offset = longint'($signed(val));
         ryam_pkg::REG_HOVER_INITIAL:   hover_avg = {val, 16'h0000};
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain;
      while (expected_attitudes.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic tick_type random_tick();
      tick_type t;
      logic [159:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t = tick_type'(bits[131:0]);
      // keep takeover to a minority so the rotator path dominates
      if ($urandom_range(0, 3) != 0) t.accept = 1'b0;
      if ($urandom_range(0, 1)) t.altitude = 16'(int'($urandom_range(0, 2000)) - 1000);
      return t;
   endfunction

   task automatic random_ticks(input int n);
      int gap;
      for (int i = 0; i < n; i++) begin
         send_tick(random_tick());
         if ($urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 30);
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic test_directed_extremes;
      tick_type t;
      logic signed [15:0] ext[4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
      for (int i = 0; i < 16; i++) begin
         t = '0;
         t.x_cmd = ext[i % 4]; t.y_cmd = ext[(i / 4) % 4];
         t.heading = ext[(i + 1) % 4]; t.altitude = ext[(i + 2) % 4];
         t.yaw_meas = ext[(i + 3) % 4];
         t.st_roll = ext[i % 4]; t.st_pitch = ext[(i + 1) % 4]; t.st_yaw = ext[(i + 2) % 4];
         t.offboard = i[0]; t.accept = i[1]; t.override_sw = i[2]; t.interrupt_sw = i[3];
         send_tick(t);
      end
      // yaw near the quadrant fold and offboard saturation
      for (int i = 0; i < 6; i++) begin
         t = random_tick();
         t.yaw_meas = (i < 3) ? 16'(6434 + i - 1) : 16'(-6434 + i - 4);
         t.offboard = 1'b1;
         send_tick(t);
      end
      drain();
   endtask

   task automatic test_config_sweep;
      // direct bits, clamp inversion, preset, extremes
      write_reg(ryam_pkg::REG_START_YAW, 16'h7FFF);
      write_reg(ryam_pkg::REG_PITCH_DIRECT, 16'h0001);
      write_reg(ryam_pkg::REG_ROLL_DIRECT, 16'h0001);
      write_reg(ryam_pkg::REG_HOVER_UPPER, 16'd8000);
      write_reg(ryam_pkg::REG_HOVER_LOWER, 16'd20000);
      write_reg(ryam_pkg::REG_ALTITUDE_OFFSET, 16'h8000);
      write_reg(ryam_pkg::REG_HOVER_INITIAL, 16'd32768);
      random_ticks(200);
      drain();
      write_reg(ryam_pkg::REG_START_YAW, 16'h8000);
      write_reg(ryam_pkg::REG_PITCH_DIRECT, 16'h0000);
      write_reg(ryam_pkg::REG_ROLL_DIRECT, 16'h0000);
      write_reg(ryam_pkg::REG_HOVER_UPPER, 16'hFFFF);
      write_reg(ryam_pkg::REG_HOVER_LOWER, 16'd0);
      write_reg(ryam_pkg::REG_ALTITUDE_OFFSET, 16'h7FFF);
      write_reg(ryam_pkg::REG_HOVER_INITIAL, 16'hFFFF);
      // unknown index is ignored
      write_reg(3'(ryam_pkg::REG_HOVER_INITIAL + 3'd1), 16'h1234);
      random_ticks(200);
      // pressure: hold off until everything is back
      while (expected_attitudes.size() != 0) @(negedge clock);
      random_ticks(100);
      drain();
      write_reg(ryam_pkg::REG_HOVER_UPPER, 16'd32768);
      write_reg(ryam_pkg::REG_HOVER_LOWER, 16'd0);
      write_reg(ryam_pkg::REG_ALTITUDE_OFFSET, 16'd0);
      write_reg(ryam_pkg::REG_HOVER_INITIAL, 16'd0);
      write_reg(ryam_pkg::REG_START_YAW, 16'($urandom));
      write_reg(ryam_pkg::REG_PITCH_DIRECT, 16'h0001);
      random_ticks(300);
      drain();
   endtask

   task automatic test_random_settings;
      for (int k = 0; k < 3; k++) begin
         write_reg(ryam_pkg::REG_START_YAW, 16'($urandom));
         write_reg(ryam_pkg::REG_PITCH_DIRECT, 16'($urandom_range(0, 1)));
         write_reg(ryam_pkg::REG_ROLL_DIRECT, 16'($urandom_range(0, 1)));
         write_reg(ryam_pkg::REG_HOVER_UPPER, 16'($urandom_range(16384, 32768)));
         write_reg(ryam_pkg::REG_HOVER_LOWER, 16'($urandom_range(0, 16384)));
         write_reg(ryam_pkg::REG_ALTITUDE_OFFSET, 16'($urandom_range(0, 4000)) - 16'd2000);
         write_reg(ryam_pkg::REG_HOVER_INITIAL, 16'($urandom_range(0, 32768)));
         random_ticks(210);
         drain();
      end
   endtask

   initial begin
      sh_start_yaw = 0; sh_pitch_direct = 0; sh_roll_direct = 0;
      sh_upper = 32768; sh_lower = 0; sh_offset = 0;
      hover_avg = {16'd16384, 16'h0000};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_config_sweep();
      test_random_settings();
      if (error_count == 0) begin
         $display("yaw_rotated_attitude_command_mixer: match");
      end else begin
         $display("yaw_rotated_attitude_command_mixer: mismatch");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
src/ryam_pkg.sv
src/ryam_mul.sv
src/ryam_cordic.sv
src/yaw_rotated_attitude_command_mixer.sv
dv/tb_yaw_rotated_attitude_command_mixer.sv
